// ===== hw/rtl/bed_pkg.sv =====
// Shared types, constants and helpers of the button event detector.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package bed_pkg;

   localparam int DEBOUNCE_THRESHOLD = 4;
   localparam int SCORE_W            = 5;
   localparam int EVENT_SLOTS        = 4;
   localparam int SLOT_CNT_W         = $clog2(EVENT_SLOTS + 1);
   localparam int FIFO_DEPTH         = 8;
   localparam int FIFO_PTR_W         = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W         = $clog2(FIFO_DEPTH + 1);

   localparam logic [2:0] CSR_ACTIVE_LEVEL      = 3'd0;
   localparam logic [2:0] CSR_DEBOUNCE_SAMPLE   = 3'd1;
   localparam logic [2:0] CSR_LONG_PRESS        = 3'd2;
   localparam logic [2:0] CSR_REPEAT            = 3'd3;
   localparam logic [2:0] CSR_MULTI_CLICK       = 3'd4;
   localparam logic [2:0] CSR_EVENT_ENABLES     = 3'd5;
   localparam logic [2:0] CSR_MENU_LEVEL        = 3'd6;

   localparam int EN_LONG_PRESS  = 0;
   localparam int EN_AUTO_REPEAT = 1;
   localparam int EN_MULTI_CLICK = 2;

   typedef enum logic [2:0] {
      PH_IDLE         = 3'd0,
      PH_PRESS_DEB    = 3'd1,
      PH_HOLD         = 3'd2,
      PH_REL_DEB      = 3'd3,
      PH_LONG_HOLD    = 3'd4,
      PH_REL_LONG_DEB = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_PRESS        = 3'd0,
      EV_RELEASE      = 3'd1,
      EV_LONG_RELEASE = 3'd2,
      EV_CLICK        = 3'd3,
      EV_LONG_PRESS   = 3'd4,
      EV_REPEAT       = 3'd5,
      EV_MULTI        = 3'd6
   } event_code_type;

   typedef struct packed {
      event_code_type code;
      logic [15:0]    param;
      logic [2:0]     menu;
      logic           last;
   } event_type;

   typedef struct packed {
      logic [SLOT_CNT_W-1:0]            count;
      event_type [EVENT_SLOTS-1:0]      slot;
   } event_batch_type;

   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/button_event_detector.sv =====
// Button event detector: one pin sample per request turns into zero to four
// events (press, release, long release, click, long press, repeat, multi
// click), delivered one per cycle while the result side is ready, with the last
// event of a request marked. A request is taken in the cycle it arrives while
// the eight-entry event queue holds at most four events, so one request a cycle
// is sustained as long as the result side drains one event a cycle; a request
// that yields several events uses that many result slots. The state update is
// combinational and registered on accept. There is no clearing pass after reset.
// Depends on bed_pkg, bed_core and bed_evq.
`default_nettype none

module button_event_detector (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_pin_level,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_event_code,
   output      logic [15:0] rsp_event_param,
   output      logic [2:0]  rsp_event_menu,
   output      logic        rsp_last_event,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   bed_pkg::event_batch_type batch;
   bed_pkg::event_type       head;
   logic                     accept;
   logic                     has_room;

   assign req_ready = has_room;
   assign accept    = req_valid && has_room;

   bed_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pin_level (req_pin_level),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .batch     (batch)
   );

   bed_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .batch     (batch),
      .pop       (rsp_ready),
      .has_room  (has_room),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_event_code  = head.code;
   assign rsp_event_param = head.param;
   assign rsp_event_menu  = head.menu;
   assign rsp_last_event  = head.last;

endmodule

`default_nettype wire

// ===== hw/rtl/bed_core.sv =====
// Button state, debounce score, hold and click timers and event generation.
// Depends on bed_pkg; produces one batch of up to four events per request.
`default_nettype none

module bed_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic                      pin_level,
   input  wire logic                      csr_wr_en,
   input  wire logic [2:0]                csr_index,
   input  wire logic [15:0]               csr_wdata,
   output      bed_pkg::event_batch_type  batch
);

   localparam logic signed [bed_pkg::SCORE_W-1:0] SCORE_POS =
      bed_pkg::SCORE_W'(bed_pkg::DEBOUNCE_THRESHOLD);
   localparam logic signed [bed_pkg::SCORE_W-1:0] SCORE_NEG = -SCORE_POS;
   localparam logic signed [bed_pkg::SCORE_W-1:0] SCORE_ONE =
      bed_pkg::SCORE_W'(1);
   localparam logic [bed_pkg::SLOT_CNT_W-1:0] SLOT_ONE = bed_pkg::SLOT_CNT_W'(1);

   logic        active_ff;
   logic [15:0] deb_ticks_ff;
   logic [15:0] long_ticks_ff;
   logic [15:0] rep_ticks_ff;
   logic [15:0] multi_ticks_ff;
   logic [2:0]  enables_ff;
   logic [2:0]  menu_ff;

   bed_pkg::phase_type                 phase_ff, phase_in, phase_mid;
   logic                               prev_ff, prev_in;
   logic signed [bed_pkg::SCORE_W-1:0] score_ff, score_in;
   logic [15:0]                        sample_ff, sample_in;
   logic [15:0]                        hold_cnt_ff, hold_cnt_in;
   logic                               hold_run_ff, hold_run_in;
   logic [15:0]                        click_cnt_ff, click_cnt_in;
   logic                               click_run_ff, click_run_in;
   logic [15:0]                        repeat_ff, repeat_in;
   logic [7:0]                         clicks_ff, clicks_in;

   logic                               pressed;
   logic                               edge_seen;
   logic                               hold_fire;
   logic                               due;
   logic                               is_long;
   logic [bed_pkg::SLOT_CNT_W-1:0]     n;

   assign pressed   = (pin_level == active_ff);
   assign edge_seen = (pin_level != prev_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         deb_ticks_ff   <= 16'd5;
         long_ticks_ff  <= 16'd1000;
         rep_ticks_ff   <= 16'd250;
         multi_ticks_ff <= 16'd300;
         enables_ff     <= 3'd0;
         menu_ff        <= 3'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            bed_pkg::CSR_ACTIVE_LEVEL:    active_ff      <= csr_wdata[0];
            bed_pkg::CSR_DEBOUNCE_SAMPLE: deb_ticks_ff   <= csr_wdata;
            bed_pkg::CSR_LONG_PRESS:      long_ticks_ff  <= csr_wdata;
            bed_pkg::CSR_REPEAT:          rep_ticks_ff   <= csr_wdata;
            bed_pkg::CSR_MULTI_CLICK:     multi_ticks_ff <= csr_wdata;
            bed_pkg::CSR_EVENT_ENABLES:   enables_ff     <= csr_wdata[2:0];
            bed_pkg::CSR_MENU_LEVEL:      menu_ff        <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bed_pkg::PH_IDLE;
         prev_ff      <= 1'b1;
         score_ff     <= '0;
         sample_ff    <= '0;
         hold_cnt_ff  <= '0;
         hold_run_ff  <= 1'b0;
         click_cnt_ff <= '0;
         click_run_ff <= 1'b0;
         repeat_ff    <= '0;
         clicks_ff    <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         prev_ff      <= prev_in;
         score_ff     <= score_in;
         sample_ff    <= sample_in;
         hold_cnt_ff  <= hold_cnt_in;
         hold_run_ff  <= hold_run_in;
         click_cnt_ff <= click_cnt_in;
         click_run_ff <= click_run_in;
         repeat_ff    <= repeat_in;
         clicks_ff    <= clicks_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      prev_in      = pin_level;
      score_in     = score_ff;
      sample_in    = sample_ff;
      hold_cnt_in  = hold_cnt_ff;
      hold_run_in  = hold_run_ff;
      click_cnt_in = click_cnt_ff;
      click_run_in = click_run_ff;
      repeat_in    = repeat_ff;
      clicks_in    = clicks_ff;
      batch        = '0;
      n            = '0;
      hold_fire    = 1'b0;
      due          = 1'b0;
      is_long      = 1'b0;
      phase_mid    = phase_ff;

      // click timer
      if (click_run_ff) begin
         if (click_cnt_ff <= 16'd1) begin
            click_cnt_in = '0;
            click_run_in = 1'b0;
            if (clicks_ff > 8'd1) begin
               batch.slot[n[1:0]].code  = bed_pkg::EV_MULTI;
               batch.slot[n[1:0]].param = {8'd0, clicks_ff};
            end else begin
               batch.slot[n[1:0]].code  = bed_pkg::EV_CLICK;
               batch.slot[n[1:0]].param = '0;
            end
            batch.slot[n[1:0]].menu = menu_ff;
            n         = n + SLOT_ONE;
            clicks_in = '0;
         end else begin
            click_cnt_in = click_cnt_ff - 16'd1;
         end
      end

      // hold timer
      if (hold_run_ff) begin
         if (hold_cnt_ff <= 16'd1) begin
            hold_cnt_in = '0;
            hold_run_in = 1'b0;
            hold_fire   = 1'b1;
         end else begin
            hold_cnt_in = hold_cnt_ff - 16'd1;
         end
      end
      if (hold_fire && pressed) begin
         if (phase_ff inside {bed_pkg::PH_REL_DEB, bed_pkg::PH_REL_LONG_DEB}) begin
            phase_in = bed_pkg::PH_REL_LONG_DEB;
         end else begin
            phase_in = bed_pkg::PH_LONG_HOLD;
         end
         batch.slot[n[1:0]].code  = bed_pkg::EV_LONG_PRESS;
         batch.slot[n[1:0]].param = '0;
         if (enables_ff[bed_pkg::EN_AUTO_REPEAT]) begin
            if (repeat_ff != 16'd0) begin
               batch.slot[n[1:0]].code = bed_pkg::EV_REPEAT;
            end
            batch.slot[n[1:0]].param = repeat_ff;
            if (repeat_ff != 16'hFFFF) begin
               repeat_in = repeat_ff + 16'd1;
            end
            hold_cnt_in = bed_pkg::at_least_one(rep_ticks_ff);
            hold_run_in = 1'b1;
         end
         batch.slot[n[1:0]].menu = menu_ff;
         n = n + SLOT_ONE;
      end
      phase_mid = phase_in;

      // pin logic
      case (phase_mid)
         bed_pkg::PH_IDLE, bed_pkg::PH_HOLD, bed_pkg::PH_LONG_HOLD: begin
            if (edge_seen) begin
               case (phase_mid)
                  bed_pkg::PH_IDLE: phase_in = bed_pkg::PH_PRESS_DEB;
                  bed_pkg::PH_HOLD: phase_in = bed_pkg::PH_REL_DEB;
                  default:          phase_in = bed_pkg::PH_REL_LONG_DEB;
               endcase
               score_in  = '0;
               sample_in = bed_pkg::at_least_one(deb_ticks_ff);
            end
         end
         bed_pkg::PH_PRESS_DEB: begin
            if (sample_ff <= 16'd1) begin
               sample_in = bed_pkg::at_least_one(deb_ticks_ff);
               due       = 1'b1;
            end else begin
               sample_in = sample_ff - 16'd1;
            end
            if (due) begin
               score_in = pressed ? score_ff + SCORE_ONE : score_ff - SCORE_ONE;
               if (score_in <= SCORE_NEG) begin
                  phase_in = bed_pkg::PH_IDLE;
               end else if (score_in >= SCORE_POS) begin
                  batch.slot[n[1:0]].code  = bed_pkg::EV_PRESS;
                  batch.slot[n[1:0]].param = '0;
                  batch.slot[n[1:0]].menu  = menu_ff;
                  n = n + SLOT_ONE;
                  if (enables_ff[bed_pkg::EN_LONG_PRESS] ||
                      enables_ff[bed_pkg::EN_AUTO_REPEAT]) begin
                     hold_cnt_in = bed_pkg::at_least_one(long_ticks_ff);
                     hold_run_in = 1'b1;
                  end
                  phase_in = bed_pkg::PH_HOLD;
               end
            end
         end
         bed_pkg::PH_REL_DEB, bed_pkg::PH_REL_LONG_DEB: begin
            is_long = (phase_mid == bed_pkg::PH_REL_LONG_DEB);
            if (sample_ff <= 16'd1) begin
               sample_in = bed_pkg::at_least_one(deb_ticks_ff);
               due       = 1'b1;
            end else begin
               sample_in = sample_ff - 16'd1;
            end
            if (due) begin
               score_in = pressed ? score_ff - SCORE_ONE : score_ff + SCORE_ONE;
               if (score_in <= SCORE_NEG) begin
                  phase_in = is_long ? bed_pkg::PH_LONG_HOLD : bed_pkg::PH_HOLD;
               end else if (score_in >= SCORE_POS) begin
                  hold_run_in = 1'b0;
                  hold_cnt_in = '0;
                  repeat_in   = '0;
                  batch.slot[n[1:0]].code  = is_long ? bed_pkg::EV_LONG_RELEASE
                                                     : bed_pkg::EV_RELEASE;
                  batch.slot[n[1:0]].param = '0;
                  batch.slot[n[1:0]].menu  = menu_ff;
                  n = n + SLOT_ONE;
                  if (!is_long) begin
                     if (enables_ff[bed_pkg::EN_MULTI_CLICK]) begin
                        click_cnt_in = bed_pkg::at_least_one(multi_ticks_ff);
                        click_run_in = 1'b1;
                        if (clicks_in != 8'hFF) begin
                           clicks_in = clicks_in + 8'd1;
                        end
                     end else begin
                        batch.slot[n[1:0]].code  = bed_pkg::EV_CLICK;
                        batch.slot[n[1:0]].param = '0;
                        batch.slot[n[1:0]].menu  = menu_ff;
                        n = n + SLOT_ONE;
                     end
                  end
                  phase_in = bed_pkg::PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = bed_pkg::PH_IDLE;
         end
      endcase

      // mark the final event of the request
      for (int i = 0; i < bed_pkg::EVENT_SLOTS; i++) begin
         batch.slot[i].last = (bed_pkg::SLOT_CNT_W'(i + 1) == n);
      end
      batch.count = n;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bed_evq.sv =====
// Event queue: takes a batch of up to four events a cycle, delivers one a cycle while popped.
// Depends on bed_pkg for the event and batch types and the queue depth.
`default_nettype none

module bed_evq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire bed_pkg::event_batch_type  batch,
   input  wire logic                      pop,
   output      logic                      has_room,
   output      logic                      not_empty,
   output      bed_pkg::event_type        head
);

   bed_pkg::event_type mem [bed_pkg::FIFO_DEPTH];

   logic [bed_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bed_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bed_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic [bed_pkg::FIFO_CNT_W-1:0] push_n;
   logic                           do_pop;

   assign has_room  = (count_ff <=
                       bed_pkg::FIFO_CNT_W'(bed_pkg::FIFO_DEPTH - bed_pkg::EVENT_SLOTS));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];
   assign do_pop    = pop && not_empty;
   assign push_n    = push ? bed_pkg::FIFO_CNT_W'(batch.count) : '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + bed_pkg::FIFO_PTR_W'(push_n);
      rd_ptr_in = do_pop ? rd_ptr_ff + bed_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + push_n - (do_pop ? bed_pkg::FIFO_CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < bed_pkg::EVENT_SLOTS; k++) begin
         if (push && (bed_pkg::SLOT_CNT_W'(k) < batch.count)) begin
            mem[bed_pkg::FIFO_PTR_W'(wr_ptr_ff + bed_pkg::FIFO_PTR_W'(k))] <= batch.slot[k];
         end
      end
   end

endmodule

`default_nettype wire
